[src/cmt_pkg.sv]
// ----------------------------------------------------------------------------
// cmt_pkg: shared types and constants for the CAN motor command node
// Holds the field widths, register indexes, drive codes, the CPR and speed
// scale tables, and the drive decode result type.
// ----------------------------------------------------------------------------
package cmt_pkg;

  // Field widths
  localparam int IdWidth     = 11;
  localparam int DataWidth   = 64;
  localparam int CountWidth  = 16;
  localparam int DevIdWidth  = 5;
  localparam int ResSelWidth = 4;
  localparam int CmdWidth    = 16;
  localparam int ModeWidth   = 2;
  localparam int DutyWidth   = 10;
  localparam int ScaleWidth  = 9;
  localparam int ProdWidth   = CountWidth + ScaleWidth;

  // Configuration port
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 5;

  localparam logic [CfgIndexWidth-1:0] RegDeviceId   = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegResolution = 2'd1;

  // Protocol constants
  localparam logic [IdWidth-1:0]    GroupBaseId = 11'h1FE;
  localparam logic [IdWidth-1:0]    TxBaseId    = 11'h20B;
  localparam logic [3:0]            ClearNibble = 4'hA;
  localparam logic [DutyWidth-1:0]  DutyMax     = 10'd999;
  localparam logic [DevIdWidth-1:0] DevIdMax    = 5'd16;

  // Mode codes carried in the command high byte
  localparam logic [1:0] CmdReverse = 2'b10;
  localparam logic [1:0] CmdForward = 2'b11;

  // Drive mode codes presented on the result
  localparam logic [ModeWidth-1:0] DriveFree    = 2'd0;
  localparam logic [ModeWidth-1:0] DriveReverse = 2'd1;
  localparam logic [ModeWidth-1:0] DriveForward = 2'd2;

  typedef struct packed {
    logic [ModeWidth-1:0] mode;
    logic [DutyWidth-1:0] duty;
  } drive_t;

  // Encoder counts per revolution selected by the DIP code.
  function automatic logic [15:0] cpr_lookup(input logic [ResSelWidth-1:0] sel);
    logic [15:0] cpr;
    unique case (sel)
      4'd0:    cpr = 16'd8192;
      4'd1:    cpr = 16'd4000;
      4'd2:    cpr = 16'd3200;
      4'd3:    cpr = 16'd1536;
      4'd4:    cpr = 16'd4096;
      4'd5:    cpr = 16'd2000;
      4'd6:    cpr = 16'd1600;
      4'd7:    cpr = 16'd768;
      4'd8:    cpr = 16'd2048;
      4'd9:    cpr = 16'd1000;
      4'd10:   cpr = 16'd800;
      4'd11:   cpr = 16'd384;
      4'd12:   cpr = 16'd1024;
      4'd13:   cpr = 16'd500;
      4'd14:   cpr = 16'd400;
      default: cpr = 16'd192;
    endcase
    return cpr;
  endfunction

  // Speed scale: 60000 divided by the CPR of the same entry, rounded down.
  function automatic logic [ScaleWidth-1:0] rpm_scale_lookup(
    input logic [ResSelWidth-1:0] sel
  );
    logic [ScaleWidth-1:0] scale;
    unique case (sel)
      4'd0:    scale = 9'd7;
      4'd1:    scale = 9'd15;
      4'd2:    scale = 9'd18;
      4'd3:    scale = 9'd39;
      4'd4:    scale = 9'd14;
      4'd5:    scale = 9'd30;
      4'd6:    scale = 9'd37;
      4'd7:    scale = 9'd78;
      4'd8:    scale = 9'd29;
      4'd9:    scale = 9'd60;
      4'd10:   scale = 9'd75;
      4'd11:   scale = 9'd156;
      4'd12:   scale = 9'd58;
      4'd13:   scale = 9'd120;
      4'd14:   scale = 9'd150;
      default: scale = 9'd312;
    endcase
    return scale;
  endfunction

endpackage

[src/cmt_drive_decode.sv]
// ----------------------------------------------------------------------------
// cmt_drive_decode: motor drive decode from the kept command bytes
// Extracts the mode code and the 10-bit duty, clamps the duty and forces
// free wheel with zero duty for unknown mode codes.
// ----------------------------------------------------------------------------
module cmt_drive_decode (
  input  logic [cmt_pkg::CmdWidth-1:0] cmd_bytes,
  output cmt_pkg::drive_t              drive
);
  import cmt_pkg::*;

  logic [1:0]           mode_code;
  logic [DutyWidth-1:0] duty_raw;
  logic [DutyWidth-1:0] duty_clamped;

  // High byte bits 3..2 carry the mode, bits 1..0 the upper duty bits.
  assign mode_code    = cmd_bytes[11:10];
  assign duty_raw     = {cmd_bytes[9:8], cmd_bytes[7:0]};
  assign duty_clamped = (duty_raw > DutyMax) ? DutyMax : duty_raw;

  always_comb begin
    unique case (mode_code)
      CmdReverse: begin
        drive.mode = DriveReverse;
        drive.duty = duty_clamped;
      end
      CmdForward: begin
        drive.mode = DriveForward;
        drive.duty = duty_clamped;
      end
      default: begin
        drive.mode = DriveFree;
        drive.duty = '0;
      end
    endcase
  end

endmodule

[src/can_motor_command_and_telemetry.sv]
// ----------------------------------------------------------------------------
// can_motor_command_and_telemetry: CAN motor command and encoder telemetry
// Keeps this node's command bytes from group frames, decodes the motor drive
// and forms one telemetry frame per millisecond tick.
// ----------------------------------------------------------------------------
// Every request (a received frame or a 1 ms tick) produces exactly one result,
// registered at the edge that accepts it; a new request can be accepted in
// every cycle while in_stall is low. The only storage between the ports is
// the result register; the command bytes and the previous encoder count are
// updated at the edge that accepts a request, so the next request already
// sees them. in_stall is high only while a result is held and out_stall is
// high. Configuration writes are always ready and take effect at the next request.
module can_motor_command_and_telemetry (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic [cmt_pkg::IdWidth-1:0]        in_msg_id,
  input  logic [cmt_pkg::DataWidth-1:0]      in_frame_data,
  input  logic signed [cmt_pkg::CountWidth-1:0] in_enc_count,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cmt_pkg::ModeWidth-1:0]      out_drive_mode,
  output logic [cmt_pkg::DutyWidth-1:0]      out_duty,
  output logic                               out_clear_encoder,
  output logic                               out_tx_valid,
  output logic [cmt_pkg::IdWidth-1:0]        out_tx_id,
  output logic [cmt_pkg::DataWidth-1:0]      out_tx_data,

  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cmt_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [cmt_pkg::CfgDataWidth-1:0]   cfg_data
);
  import cmt_pkg::*;

  // Registers
  logic                     out_valid_r;
  logic [DevIdWidth-1:0]    dev_id_r;
  logic [ResSelWidth-1:0]   res_sel_r;
  logic [CmdWidth-1:0]      cmd_r;
  logic [CmdWidth-1:0]      cmd_nxt;
  logic [CountWidth-1:0]    prev_count_r;
  logic [ModeWidth-1:0]     drive_mode_r;
  logic [DutyWidth-1:0]     duty_r;
  logic                     clear_r;
  logic                     tx_valid_r;
  logic [IdWidth-1:0]       tx_id_r;
  logic [DataWidth-1:0]     tx_data_r;

  logic                     in_accept;
  logic [DevIdWidth-1:0]    dev_minus1;
  logic                     dev_in_range;
  logic [IdWidth-1:0]       group_id;
  logic                     id_match;
  logic [CmdWidth-1:0]      frame_pair;
  logic                     clear_hit;
  logic [CountWidth-1:0]    count_u;
  logic [CountWidth-1:0]    delta;
  logic [ProdWidth-1:0]     rpm_prod;
  logic [15:0]              cpr;
  logic [IdWidth-1:0]       tx_id;
  drive_t                   drive;

  // Handshakes
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Command group match and byte pair selection.
  assign dev_minus1   = dev_id_r - 5'd1;
  assign dev_in_range = (dev_id_r != '0) && (dev_id_r <= DevIdMax);
  assign group_id     = GroupBaseId - {{(IdWidth-2){1'b0}}, dev_minus1[3:2]};
  assign id_match     = dev_in_range && (in_msg_id == group_id);

  always_comb begin
    unique case (dev_minus1[1:0])
      2'd0:    frame_pair = in_frame_data[63:48];
      2'd1:    frame_pair = in_frame_data[47:32];
      2'd2:    frame_pair = in_frame_data[31:16];
      default: frame_pair = in_frame_data[15:0];
    endcase
  end

  assign cmd_nxt   = (in_accept && !in_func && id_match) ? frame_pair : cmd_r;
  assign clear_hit = (cmd_nxt[15:12] == ClearNibble);

  // Drive decode works on the command bytes as they stand after this request.
  cmt_drive_decode u_drive_decode (
    .cmd_bytes (cmd_nxt),
    .drive     (drive)
  );

  // Speed: wrapping count delta times the table scale, low 16 bits kept.
  assign count_u  = in_enc_count;
  assign delta    = count_u - prev_count_r;
  assign rpm_prod = {{ScaleWidth{1'b0}}, delta} *
                    {{CountWidth{1'b0}}, rpm_scale_lookup(res_sel_r)};
  assign cpr      = cpr_lookup(res_sel_r);
  assign tx_id    = TxBaseId + {{(IdWidth-DevIdWidth){1'b0}}, dev_id_r};

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      dev_id_r     <= 5'd1;
      res_sel_r    <= '0;
      cmd_r        <= '0;
      prev_count_r <= '0;
    end else begin
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      cmd_r <= cmd_nxt;
      if (in_accept && in_func) begin
        prev_count_r <= count_u;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          RegDeviceId:   dev_id_r  <= cfg_data;
          RegResolution: res_sel_r <= cfg_data[ResSelWidth-1:0];
          default:       ;
        endcase
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      drive_mode_r <= drive.mode;
      duty_r       <= drive.duty;
      if (in_func) begin
        clear_r    <= 1'b0;
        tx_valid_r <= 1'b1;
        tx_id_r    <= tx_id;
        tx_data_r  <= {count_u, rpm_prod[15:0], 16'h0000, cpr};
      end else begin
        clear_r    <= clear_hit;
        tx_valid_r <= 1'b0;
        tx_id_r    <= '0;
        tx_data_r  <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_mode    = drive_mode_r;
  assign out_duty          = duty_r;
  assign out_clear_encoder = clear_r;
  assign out_tx_valid      = tx_valid_r;
  assign out_tx_id         = tx_id_r;
  assign out_tx_data       = tx_data_r;

`ifndef SYNTHESIS
  // The input side only stalls while a result is held.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no result held");

  // An accepted tick shows up as a telemetry result in the next cycle.
  a_tick_gives_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func) |=> (out_valid && out_tx_valid))
    else $error("tick did not produce a telemetry result");

  // Telemetry results never request an encoder clear.
  a_tx_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tx_valid) |-> !out_clear_encoder)
    else $error("encoder clear on a telemetry result");

  // Free wheel always carries zero duty.
  a_free_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_drive_mode == DriveFree)) |-> (out_duty == '0))
    else $error("nonzero duty in free wheel");
`endif

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the CAN motor command and telemetry node
// Sends received frames and 1 ms ticks through the request channel and
// predicts the drive decode, the encoder clear and the telemetry frame for
// each one. Every result is checked against the oldest prediction. The run
// covers every node number class and every CPR code, with random idling
// on both sides and a long hold on the result side.
// ----------------------------------------------------------------------------
module tb;
  import cmt_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int PhaseCount = 16;
  localparam int PhaseItems = 120;

  localparam logic FuncFrame = 1'b0;
  localparam logic FuncTick  = 1'b1;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CfgIndexWidth-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegSpareHi = 2'd3;

  localparam logic [15:0] CprTable [16] = '{
    16'd8192, 16'd4000, 16'd3200, 16'd1536, 16'd4096, 16'd2000, 16'd1600, 16'd768,
    16'd2048, 16'd1000, 16'd800,  16'd384,  16'd1024, 16'd500,  16'd400,  16'd192
  };

  // Node numbers per phase: all four groups, both ends and invalid numbers.
  localparam logic [DevIdWidth-1:0] DevPlan [PhaseCount] = '{
    5'd4, 5'd16, 5'd5, 5'd0, 5'd9, 5'd13, 5'd31, 5'd8,
    5'd1, 5'd12, 5'd17, 5'd2, 5'd3, 5'd6, 5'd14, 5'd20
  };

  typedef struct packed {
    logic                  func;
    logic [IdWidth-1:0]    msg_id;
    logic [DataWidth-1:0]  frame_data;
    logic [CountWidth-1:0] enc_count;
  } motor_req_t;

  typedef struct packed {
    logic [ModeWidth-1:0] drive_mode;
    logic [DutyWidth-1:0] duty;
    logic                 clear_encoder;
    logic                 tx_valid;
    logic [IdWidth-1:0]   tx_id;
    logic [DataWidth-1:0] tx_data;
  } motor_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid      = 1'b0;
  logic                         in_stall;
  logic                         in_func       = 1'b0;
  logic [IdWidth-1:0]           in_msg_id     = '0;
  logic [DataWidth-1:0]         in_frame_data = '0;
  logic signed [CountWidth-1:0] in_enc_count  = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ModeWidth-1:0] out_drive_mode;
  logic [DutyWidth-1:0] out_duty;
  logic                 out_clear_encoder;
  logic                 out_tx_valid;
  logic [IdWidth-1:0]   out_tx_id;
  logic [DataWidth-1:0] out_tx_data;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data  = '0;

  // Mirror of the node's registers and state.
  logic [DevIdWidth-1:0]  node_dev_id  = 5'd1;
  logic [ResSelWidth-1:0] node_res_sel = 4'd0;
  logic [CmdWidth-1:0]    kept_cmd     = '0;
  logic [CountWidth-1:0]  last_count   = '0;

  motor_req_t    pending_requests[$];
  motor_result_t expected_results[$];

  logic req_accepted = 1'b0;
  logic res_taken    = 1'b0;
  logic rx_hold      = 1'b0;
  int   send_gap_max = 0;
  int   recv_gap_max = 0;
  int   send_wait    = 0;
  int   stall_left   = 0;
  int   cycle_count  = 0;
  int   mismatch_count  = 0;
  int   results_checked = 0;
  int   frames_taken    = 0;
  int   ticks_taken     = 0;
  event hold_kick;

  can_motor_command_and_telemetry dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_msg_id         (in_msg_id),
    .in_frame_data     (in_frame_data),
    .in_enc_count      (in_enc_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_mode    (out_drive_mode),
    .out_duty          (out_duty),
    .out_clear_encoder (out_clear_encoder),
    .out_tx_valid      (out_tx_valid),
    .out_tx_id         (out_tx_id),
    .out_tx_data       (out_tx_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  // Computes the result of one request and advances the mirrored state.
  function automatic motor_result_t predict_motor_result(input motor_req_t r);
    motor_result_t        res;
    logic [DevIdWidth-1:0] dev_less;
    logic [7:0]           hi;
    logic [DutyWidth-1:0] level;
    logic [15:0]          cpr;
    logic [15:0]          delta;
    logic [31:0]          rpm;
    res = '0;
    dev_less = node_dev_id - 5'd1;
    if (r.func == FuncFrame) begin
      // Only the node's own group takes the frame; the byte pair wraps by node number.
      if (node_dev_id >= 5'd1 && node_dev_id <= DevIdMax &&
          r.msg_id == GroupBaseId - IdWidth'(dev_less[4:2]))
        kept_cmd = r.frame_data[63 - 16 * int'(dev_less[1:0]) -: 16];
      res.clear_encoder = (kept_cmd[15:12] == ClearNibble);
    end else begin
      // Telemetry: wrapping delta scaled by the truncated 60000 / CPR.
      cpr = CprTable[node_res_sel];
      delta = r.enc_count - last_count;
      rpm = delta * (60000 / cpr);
      last_count = r.enc_count;
      res.tx_valid = 1'b1;
      res.tx_id = TxBaseId + IdWidth'(node_dev_id);
      res.tx_data = {r.enc_count, rpm[15:0], 16'h0000, cpr};
    end
    // Drive decode from the kept bytes, duty clamped.
    hi = kept_cmd[15:8];
    level = {hi[1:0], kept_cmd[7:0]};
    if (level > DutyMax) level = DutyMax;
    case (hi[3:2])
      CmdReverse: begin
        res.drive_mode = DriveReverse;
        res.duty = level;
      end
      CmdForward: begin
        res.drive_mode = DriveForward;
        res.duty = level;
      end
      default: begin
        res.drive_mode = DriveFree;
        res.duty = '0;
      end
    endcase
    return res;
  endfunction

  task automatic push_frame(input logic [IdWidth-1:0] id, input logic [DataWidth-1:0] data);
    motor_req_t r;
    r.func = FuncFrame;
    r.msg_id = id;
    r.frame_data = data;
    r.enc_count = 16'($urandom);
    pending_requests.push_back(r);
  endtask

  task automatic push_tick(input logic [CountWidth-1:0] count);
    motor_req_t r;
    r.func = FuncTick;
    r.msg_id = IdWidth'($urandom);
    r.frame_data = {$urandom, $urandom};
    r.enc_count = count;
    pending_requests.push_back(r);
  endtask

  // Random requests, mostly aimed at the node's own group and byte pair.
  task automatic push_random_requests(input int count);
    motor_req_t            r;
    logic [DevIdWidth-1:0] dev_less;
    int                    k;
    dev_less = node_dev_id - 5'd1;
    k = int'(dev_less[1:0]);
    repeat (count) begin
      r.func = ($urandom_range(0, 2) == 0) ? FuncTick : FuncFrame;
      r.msg_id = IdWidth'($urandom);
      r.frame_data = {$urandom, $urandom};
      r.enc_count = 16'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          if (node_dev_id >= 5'd1 && node_dev_id <= DevIdMax)
            r.msg_id = GroupBaseId - IdWidth'(dev_less[4:2]);
          else
            r.msg_id = GroupBaseId - IdWidth'($urandom_range(0, 3));
        end
        5, 6, 7: r.msg_id = GroupBaseId - IdWidth'($urandom_range(0, 3));
        default: ;
      endcase
      // Push the duty toward the clamp edge and hit the clear nibble now and then.
      if ($urandom_range(0, 3) == 0) begin
        r.frame_data[57 - 16 * k -: 2] = 2'b11;
        r.frame_data[55 - 16 * k -: 8] = 8'($urandom_range(8'hE0, 8'hFF));
      end
      if ($urandom_range(0, 5) == 0)
        r.frame_data[63 - 16 * k -: 4] = ClearNibble;
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       r.enc_count = 16'h0000;
          1:       r.enc_count = 16'h7FFF;
          2:       r.enc_count = 16'h8000;
          default: r.enc_count = 16'hFFFF;
        endcase
      end
      pending_requests.push_back(r);
    end
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every request has gone in and every result has come out.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Request driver: one request per handshake, random gap before each.
  always @(negedge clk) begin
    motor_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_accepted) begin
      if (send_wait > 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (pending_requests.size() > 0) begin
        nxt = pending_requests.pop_front();
        in_valid      <= 1'b1;
        in_func       <= nxt.func;
        in_msg_id     <= nxt.msg_id;
        in_frame_data <= nxt.frame_data;
        in_enc_count  <= nxt.enc_count;
        send_wait = $urandom_range(0, send_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall: a random wait per result, overridden by the long hold.
  always @(negedge clk) begin
    if (res_taken) stall_left = $urandom_range(0, recv_gap_max);
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (rx_hold) begin
      out_stall <= 1'b1;
    end else if (out_valid && stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Long hold on the result side, counted here once started.
  always begin
    @(hold_kick);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Monitor: register writes, result checks and predictions for new requests.
  always @(posedge clk) begin
    motor_result_t seen;
    motor_result_t want;
    if (!rst_n) begin
      req_accepted <= 1'b0;
      res_taken    <= 1'b0;
    end else begin
      req_accepted <= in_valid && !in_stall;
      res_taken    <= out_valid && !out_stall;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegDeviceId)
          node_dev_id = cfg_data;
        else if (cfg_index == RegResolution)
          node_res_sel = cfg_data[ResSelWidth-1:0];
      end
      if (out_valid && !out_stall) begin
        seen = '{out_drive_mode, out_duty, out_clear_encoder, out_tx_valid,
                 out_tx_id, out_tx_data};
        results_checked++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result %0d: mode %0d duty %0d clear %0b tx %0b id %h data %h",
                     results_checked, seen.drive_mode, seen.duty, seen.clear_encoder,
                     seen.tx_valid, seen.tx_id, seen.tx_data);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result %0d mismatch (expected/actual): mode %0d/%0d duty %0d/%0d",
                        " clear %0b/%0b tx %0b/%0b id %h/%h data %h/%h"},
                       results_checked, want.drive_mode, seen.drive_mode, want.duty,
                       seen.duty, want.clear_encoder, seen.clear_encoder, want.tx_valid,
                       seen.tx_valid, want.tx_id, seen.tx_id, want.tx_data, seen.tx_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_func == FuncTick) ticks_taken++;
        else frames_taken++;
        expected_results.push_back(predict_motor_result(
          '{in_func, in_msg_id, in_frame_data, in_enc_count}));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[can_motor_command_and_telemetry] ERROR");
      $finish;
    end
  end

  // Stimulus: directed requests at reset settings, then one random phase per setting.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Speed wrap and count extremes at the default CPR.
    push_tick(16'h0000);
    push_tick(16'h7FFF);
    push_tick(16'h8000);
    push_tick(16'hFFFF);
    push_tick(16'h0000);
    // Mode decode and the duty clamp on the node's own byte pair.
    push_frame(GroupBaseId, 64'h0FFF_0000_0000_0000);
    push_frame(GroupBaseId, 64'h0BE7_FFFF_FFFF_FFFF);
    push_frame(GroupBaseId, 64'h0BE8_0000_0000_0000);
    push_frame(GroupBaseId, 64'h0800_1234_5678_9ABC);
    push_frame(GroupBaseId, 64'h0C01_0000_0000_0000);
    push_frame(GroupBaseId, 64'h07FF_0000_0000_0000);
    push_frame(GroupBaseId, 64'h03FF_0000_0000_0000);
    // Clear requests, then foreign frames that keep the stored clear nibble.
    push_frame(GroupBaseId, 64'hA000_0000_0000_0000);
    push_frame(GroupBaseId, 64'hAEFF_0000_0000_0000);
    push_frame(GroupBaseId - 11'd1, 64'h0000_0000_0000_0000);
    push_frame(11'h7FF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_frame(11'h000, 64'h0000_0000_0000_0000);
    push_frame(GroupBaseId, 64'hFFFF_FFFF_FFFF_FFFF);
    push_tick(16'h1234);
    push_frame(GroupBaseId, 64'h0000_ABCD_ABCD_ABCD);
    wait_idle();

    for (int p = 0; p < PhaseCount; p++) begin
      write_reg(RegDeviceId, DevPlan[p]);
      write_reg(RegResolution, {1'($urandom), 4'(15 + 7 * p)});
      write_reg((p % 2 == 0) ? RegSpareLo : RegSpareHi, 5'($urandom));
      case (p % 3)
        0: begin
          send_gap_max = 0;
          recv_gap_max = 0;
        end
        1: begin
          send_gap_max = 10;
          recv_gap_max = 10;
        end
        default: begin
          send_gap_max = (p % 2 == 0) ? 0 : 10;
          recv_gap_max = (p % 2 == 0) ? 10 : 2;
        end
      endcase
      push_random_requests(PhaseItems);
      // Back-to-back requests against a held result channel fill the node.
      if (p == 0) -> hold_kick;
      wait_idle();
    end

    repeat (5) @(posedge clk);
    $display("Checked %0d results from %0d frames and %0d ticks over %0d node settings,",
             results_checked, frames_taken, ticks_taken, PhaseCount + 1);
    $display("all CPR codes, invalid node numbers, spare register writes and a long hold.");
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("[can_motor_command_and_telemetry] OK");
    else
      $display("[can_motor_command_and_telemetry] ERROR");
    $finish;
  end

endmodule

[files.f]
src/cmt_pkg.sv
src/cmt_drive_decode.sv
src/can_motor_command_and_telemetry.sv
dv/tb.sv
